// File: rtl/bloom_filter_insert_fnv_core_assert.svh
// assertion macros for the bloom filter insert core
`ifndef BLOOM_FILTER_INSERT_FNV_CORE_ASSERT_SVH
`define BLOOM_FILTER_INSERT_FNV_CORE_ASSERT_SVH

// checked on every rising edge, masked while reset is high
`define BFI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define BFI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/bfi_pkg.sv
// shared constants, types and the hash step of the bloom filter insert core
package bfi_pkg;

  // filter geometry
  localparam int FILTER_BITS  = 4096;
  localparam int FILTER_WORDS = FILTER_BITS / 32;
  localparam int WORD_AW      = $clog2(FILTER_WORDS);
  localparam int POS_W        = $clog2(FILTER_BITS);

  // command queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // input opcodes
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result kinds, also used as command kinds in the queue
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SEED_A    = 2'd0;
  localparam logic [1:0] CFG_SEED_B    = 2'd1;
  localparam logic [1:0] CFG_REQ_LEN   = 2'd2;
  localparam logic [1:0] CFG_LEN_CHECK = 2'd3;

  // configuration reset values
  localparam logic [31:0] SEED_A_RST    = 32'h15a4db35;
  localparam logic [31:0] SEED_B_RST    = 32'h76a54d32;
  localparam logic [7:0]  REQ_LEN_RST   = 8'd35;
  localparam logic        LEN_CHECK_RST = 1'b1;

  // one queued command
  typedef struct packed {
    logic [1:0]       kind;
    logic             accepted;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [6:0]       word;
  } cmd_t;

  // queue status
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   count;
  } qstat_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [11:0] pos_a;
    logic [11:0] pos_b;
    logic [31:0] data;
  } res_t;

  // fnv-1a step: (h ^ b) * 0x01000193 as shifted adds
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

// File: rtl/bfi_ram.sv
// generic single write, single read ram with registered read data
module bfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bfi_front.sv
// front end: config registers, item intake, running hashes and command issue
module bfi_front import bfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  input  logic [6:0]  word_index,
  input  qstat_t      qstat,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [31:0] seed_a;
  logic [31:0] seed_b;
  logic [7:0]  required_length;
  logic        length_check;

  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [7:0]  byte_count;

  logic        accept;
  logic        key_item;
  logic [31:0] ha_new;
  logic [31:0] hb_new;
  logic [7:0]  count_inc;
  logic        ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a          <= SEED_A_RST;
      seed_b          <= SEED_B_RST;
      required_length <= REQ_LEN_RST;
      length_check    <= LEN_CHECK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED_A:    seed_a          <= cfg_data;
        CFG_SEED_B:    seed_b          <= cfg_data;
        CFG_REQ_LEN:   required_length <= cfg_data[7:0];
        CFG_LEN_CHECK: length_check    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // intake: stall only when the queue has no room
  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign key_item = accept && (opcode == OP_KEY);

  // hash step, a new key starts from the seeds
  assign ha_new    = fnv_step((byte_count == 8'd0) ? seed_a : hash_a, key_byte);
  assign hb_new    = fnv_step((byte_count == 8'd0) ? seed_b : hash_b, key_byte);
  assign count_inc = (byte_count == 8'hff) ? byte_count : byte_count + 8'd1;
  assign ok        = !length_check || (count_inc == required_length);

  // byte counter, back to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
    end else if (key_item) begin
      byte_count <= last_byte ? 8'd0 : count_inc;
    end
  end

  // running hashes, only meaningful while a key is open
  always_ff @(posedge clk) begin
    if (key_item && !last_byte) begin
      hash_a <= ha_new;
      hash_b <= hb_new;
    end
  end

  // command issue
  always_comb begin
    push     = 1'b0;
    push_cmd = '{kind: KIND_CLEAR, accepted: 1'b0, pos_a: '0, pos_b: '0, word: word_index};
    unique case (opcode)
      OP_KEY: begin
        push              = accept && last_byte;
        push_cmd.kind     = KIND_INSERT;
        push_cmd.accepted = ok;
        push_cmd.pos_a    = ok ? ha_new[POS_W-1:0] : '0;
        push_cmd.pos_b    = ok ? hb_new[POS_W-1:0] : '0;
      end
      OP_CLEAR: begin
        push          = accept;
        push_cmd.kind = KIND_CLEAR;
      end
      OP_READ: begin
        push          = accept;
        push_cmd.kind = KIND_READ;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/bfi_queue.sv
// short command queue between front and back end
module bfi_queue import bfi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assign head        = entries[rptr];
  assign qstat.count = count;
  assign qstat.full  = (count == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);

endmodule

// File: rtl/bfi_back.sv
// back end: filter ram with valid bits, read-modify-write of inserts, result register
module bfi_back import bfi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qstat_t qstat,
  input  cmd_t   head,
  output logic   pop,
  input  logic   out_stall,
  output logic   out_valid,
  output res_t   res,
  output logic   busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_INS_A = 2'd2;
  localparam logic [1:0] ST_INS_B = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [FILTER_WORDS-1:0] valid_bits;
  logic                    rvalid;
  logic [POS_W-1:0]        cur_a;
  logic [POS_W-1:0]        cur_b;

  logic               out_free;
  logic               ren;
  logic [WORD_AW-1:0] raddr;
  logic               we;
  logic [WORD_AW-1:0] waddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;
  logic [31:0]        old_word;
  logic [WORD_AW-1:0] wa;
  logic [WORD_AW-1:0] wb;
  logic [31:0]        bit_a;
  logic [31:0]        bit_b;
  logic               same;
  logic               load;
  logic               clr;
  res_t               res_next;
  res_t               report;

  bfi_ram #(
    .WIDTH (32),
    .DEPTH (FILTER_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // a word never written since reset or clear reads as zero
  assign old_word = rvalid ? rdata : 32'd0;
  assign wa       = cur_a[POS_W-1:5];
  assign wb       = cur_b[POS_W-1:5];
  assign bit_a    = 32'd1 << cur_a[4:0];
  assign bit_b    = 32'd1 << cur_b[4:0];
  assign same     = (wa == wb);
  assign report   = '{kind: KIND_INSERT, accepted: 1'b1, pos_a: 12'(cur_a),
                      pos_b: 12'(cur_b), data: 32'd0};

  // take a command only when the result register is free
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !qstat.empty && out_free;
  assign busy     = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    ren        = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = 32'd0;
    load       = 1'b0;
    clr        = 1'b0;
    res_next   = '{kind: KIND_CLEAR, accepted: 1'b0, pos_a: '0, pos_b: '0, data: 32'd0};
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          unique case (head.kind)
            KIND_READ: begin
              ren        = 1'b1;
              raddr      = head.word[WORD_AW-1:0];
              state_next = ST_READ;
            end
            KIND_INSERT: begin
              if (head.accepted) begin
                ren        = 1'b1;
                raddr      = head.pos_a[POS_W-1:5];
                state_next = ST_INS_A;
              end else begin
                load          = 1'b1;
                res_next.kind = KIND_INSERT;
              end
            end
            KIND_CLEAR: begin
              clr  = 1'b1;
              load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        load          = 1'b1;
        res_next.kind = KIND_READ;
        res_next.data = old_word;
        state_next    = ST_IDLE;
      end
      ST_INS_A: begin
        we    = 1'b1;
        waddr = wa;
        wdata = old_word | bit_a | (same ? bit_b : 32'd0);
        if (same) begin
          load       = 1'b1;
          res_next   = report;
          state_next = ST_IDLE;
        end else begin
          ren        = 1'b1;
          raddr      = wb;
          state_next = ST_INS_B;
        end
      end
      ST_INS_B: begin
        we         = 1'b1;
        waddr      = wb;
        wdata      = old_word | bit_b;
        load       = 1'b1;
        res_next   = report;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (clr) begin
        valid_bits <= '0;
      end else if (we) begin
        valid_bits[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ren) begin
      rvalid <= valid_bits[raddr];
    end
    if (pop) begin
      cur_a <= head.pos_a;
      cur_b <= head.pos_b;
    end
    if (load) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/bloom_filter_insert_fnv_core.sv
// top level of the two-hash fnv-1a bloom filter insert core
//
//   channel  handshake             payload
//   in       in_valid / in_stall   opcode, key_byte, last_byte, word_index
//   out      out_valid / out_stall result_kind, accepted, position_a, position_b, word_data
//   cfg      cfg_we                cfg_index, cfg_data
//
// key bytes are taken one per cycle while the queue has room; the front end hashes them as
// they arrive. in the back end a clear or rejected key is handled in idle, a word read goes
// through the read state (registered ram read), an accepted key through ins_a and, for two
// filter words, ins_b (read-modify-write on the single ram port); a 4-entry queue absorbs
// the difference. reset clears all per-word valid bits, so no clearing pass follows it.
// a stall on out holds the result and the back end; the front runs on until the queue fills.
`include "bloom_filter_insert_fnv_core_assert.svh"

module bloom_filter_insert_fnv_core import bfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  input  logic [6:0]  word_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic        accepted,
  output logic [11:0] position_a,
  output logic [11:0] position_b,
  output logic [31:0] word_data
);

  logic   q_push;
  cmd_t   q_push_cmd;
  logic   q_pop;
  cmd_t   q_head;
  qstat_t qstat;
  res_t   res;
  logic   bk_busy;

  bfi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .key_byte   (key_byte),
    .last_byte  (last_byte),
    .word_index (word_index),
    .qstat      (qstat),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  bfi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .qstat    (qstat)
  );

  bfi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (q_head),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res),
    .busy      (bk_busy)
  );

  // result fields
  assign result_kind = res.kind;
  assign accepted    = res.accepted;
  assign position_a  = res.pos_a;
  assign position_b  = res.pos_b;
  assign word_data   = res.data;

  // checks
  `BFI_ASSERT(a_busy_no_result, bk_busy |-> !out_valid, "result shown while back end busy")
  `BFI_ASSERT(a_pop_nonempty, q_pop |-> (qstat.count != '0), "pop from empty queue")
  `BFI_ASSERT(a_other_fields_zero,
    (out_valid && result_kind != KIND_INSERT) |->
      (!accepted && position_a == 12'd0 && position_b == 12'd0),
    "read or clear result has insert fields set")
  `BFI_ASSERT(a_reject_zero,
    (out_valid && result_kind == KIND_INSERT && !accepted) |->
      (position_a == 12'd0 && position_b == 12'd0 && word_data == 32'd0),
    "rejected key reports positions")
  `BFI_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result present right after reset")

endmodule

// File: verif/tb.sv
// testbench for the two-hash fnv-1a bloom filter insert core
`timescale 1ns / 100ps

module tb;
  import bfi_pkg::*;

  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  // opcode that the block ignores
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  // one result item as the filter should report it
  typedef struct {
    logic [1:0]  kind;
    logic        acc;
    logic [11:0] pos_a;
    logic [11:0] pos_b;
    logic [31:0] data;
  } bloom_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SEED_A;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_KEY;
  logic [7:0]  key_byte = '0;
  logic        last_byte = 1'b0;
  logic [6:0]  word_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic        accepted;
  logic [11:0] position_a;
  logic [11:0] position_b;
  logic [31:0] word_data;

  // shadow copy of the registers, key state and filter
  logic [31:0] cfg_seed_a = SEED_A_RST;
  logic [31:0] cfg_seed_b = SEED_B_RST;
  logic [7:0]  cfg_req_len = REQ_LEN_RST;
  logic        cfg_len_check = LEN_CHECK_RST;
  logic [31:0] hash_a = SEED_A_RST;
  logic [31:0] hash_b = SEED_B_RST;
  logic [7:0]  key_len = '0;
  logic [31:0] shadow_filter [FILTER_WORDS];

  bloom_result_t pending_results[$];

  bit quiet_run = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int keys_inserted = 0;
  int keys_rejected = 0;

  bloom_filter_insert_fnv_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .key_byte(key_byte), .last_byte(last_byte), .word_index(word_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .accepted(accepted),
    .position_a(position_a), .position_b(position_b), .word_data(word_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int w = 0; w < FILTER_WORDS; w++) shadow_filter[w] = '0;
  end

  // one fnv-1a round
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  // advance the shadow filter by one accepted item and queue the result it causes
  task automatic bloom_update(input logic [1:0] op, input logic [7:0] kb, input logic lb,
                              input logic [6:0] wi);
    bloom_result_t r;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] pa;
    logic [31:0] pb;
    logic ok;
    r = '{kind: KIND_INSERT, acc: 1'b0, pos_a: '0, pos_b: '0, data: '0};
    case (op)
      OP_KEY: begin
        ha = fnv_mix((key_len == 0) ? cfg_seed_a : hash_a, kb);
        hb = fnv_mix((key_len == 0) ? cfg_seed_b : hash_b, kb);
        if (key_len != 8'hff) key_len++;
        if (!lb) begin
          hash_a = ha;
          hash_b = hb;
        end else begin
          ok = !cfg_len_check || (key_len == cfg_req_len);
          if (ok) begin
            pa = ha & (FILTER_BITS - 1);
            pb = hb & (FILTER_BITS - 1);
            shadow_filter[pa[POS_W-1:5]][pa[4:0]] = 1'b1;
            shadow_filter[pb[POS_W-1:5]][pb[4:0]] = 1'b1;
            r.pos_a = pa[11:0];
            r.pos_b = pb[11:0];
            keys_inserted++;
          end else begin
            keys_rejected++;
          end
          r.acc = ok;
          hash_a = cfg_seed_a;
          hash_b = cfg_seed_b;
          key_len = '0;
          pending_results.push_back(r);
        end
      end
      OP_CLEAR: begin
        for (int w = 0; w < FILTER_WORDS; w++) shadow_filter[w] = '0;
        r.kind = KIND_CLEAR;
        pending_results.push_back(r);
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.data = (wi < FILTER_WORDS) ? shadow_filter[wi] : '0;
        pending_results.push_back(r);
      end
      default: begin
        // the unused opcode is ignored
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    bloom_result_t e;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
               $time, result_kind, word_data);
      errors++;
    end else begin
      e = pending_results.pop_front();
      compare_field("result_kind", 32'(e.kind), 32'(result_kind));
      compare_field("accepted", 32'(e.acc), 32'(accepted));
      compare_field("position_a", 32'(e.pos_a), 32'(position_a));
      compare_field("position_b", 32'(e.pos_b), 32'(position_b));
      compare_field("word_data", e.data, word_data);
    end
  endtask

  // watch both channels and the register port at every edge, in a fixed order
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED_A:    cfg_seed_a = cfg_data;
          CFG_SEED_B:    cfg_seed_b = cfg_data;
          CFG_REQ_LEN:   cfg_req_len = cfg_data[7:0];
          CFG_LEN_CHECK: cfg_len_check = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) bloom_update(opcode, key_byte, last_byte, word_index);
      if (out_valid && !out_stall) check_result();
    end
  end

  // receiver stalls at random unless a quiet stretch is running
  always @(posedge clk) begin
    out_stall <= !quiet_run && ($urandom_range(99) < 33);
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [7:0] kb, input logic lb,
                           input logic [6:0] wi);
    while (!quiet_run && ($urandom_range(99) < 33)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    key_byte   <= kb;
    last_byte  <= lb;
    word_index <= wi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // a key of len random bytes, last flag on the final one
  task automatic send_key(input int len);
    for (int i = 1; i <= len; i++)
      send_item(OP_KEY, 8'($urandom_range(255)), i == len, 7'($urandom_range(127)));
  endtask

  task automatic send_read(input logic [6:0] wi);
    send_item(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), wi);
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
              7'($urandom_range(127)));
  endtask

  // stop sending, let every result come back and the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write all four registers on consecutive edges
  task automatic set_config(input logic [31:0] sa, input logic [31:0] sb,
                            input logic [7:0] rl, input logic lc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEED_A;
    cfg_data  <= sa;
    @(posedge clk);
    cfg_index <= CFG_SEED_B;
    cfg_data  <= sb;
    @(posedge clk);
    cfg_index <= CFG_REQ_LEN;
    cfg_data  <= {24'd0, rl};
    @(posedge clk);
    cfg_index <= CFG_LEN_CHECK;
    cfg_data  <= {31'd0, lc};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // filter is empty after reset, ignored opcode, short key rejected at the reset length
  task automatic test_after_reset();
    send_read(7'd0);
    send_read(7'd127);
    send_item(OP_UNUSED, 8'hff, 1'b1, 7'h7f);
    send_clear();
    send_item(OP_KEY, 8'h00, 1'b1, 7'd0);
    wait_idle();
  endtask

  // single-byte keys at byte extremes, then reads of the words they hit
  task automatic test_basic_ops();
    set_config(32'h0000_0000, 32'hffff_ffff, 8'd1, 1'b1);
    send_item(OP_KEY, 8'h00, 1'b1, 7'h7f);
    send_item(OP_KEY, 8'hff, 1'b1, 7'h00);
    send_read(7'(fnv_mix(32'h0000_0000, 8'h00) >> 5));
    send_read(7'(fnv_mix(32'hffff_ffff, 8'hff) >> 5));
    send_item(OP_KEY, 8'h00, 1'b0, 7'h00);
    send_item(OP_UNUSED, 8'h55, 1'b0, 7'h2a);
    send_item(OP_KEY, 8'hff, 1'b1, 7'h7f);
    wait_idle();
  endtask

  // length check off, clear in the middle of a key, required length zero
  task automatic test_length_rules();
    set_config(32'h5a5a_5a5a, 32'ha5a5_a5a5, 8'd255, 1'b0);
    send_key(3);
    send_item(OP_KEY, 8'h3c, 1'b0, 7'd0);
    send_clear();
    send_read(7'd127);
    send_item(OP_KEY, 8'hc3, 1'b1, 7'd0);
    send_read(7'(fnv_mix(fnv_mix(32'h5a5a_5a5a, 8'h3c), 8'hc3) >> 5));
    wait_idle();
    set_config(32'hffff_ffff, 32'h0000_0000, 8'd0, 1'b1);
    send_key(1);
    send_key(2);
    wait_idle();
  endtask

  // keys around the saturating byte counter
  task automatic test_long_keys();
    set_config($urandom, $urandom, 8'd255, 1'b1);
    send_key(254);
    send_key(255);
    send_key(300);
    for (int i = 0; i < 4; i++) send_read(7'($urandom_range(127)));
    wait_idle();
  endtask

  // mostly well-formed keys with random content, plus reads, clears and noise
  task automatic random_phase(input int quota, input logic [7:0] rl, input logic lc);
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (!lc || rl == 0) len = $urandom_range(1, 6);
      else if ($urandom_range(99) < 85) len = int'(rl);
      else len = $urandom_range(1, rl + 2);
      if (pick < 65) begin
        send_key(len);
      end else if (pick < 82) begin
        send_read(7'($urandom_range(127)));
      end else if (pick < 85) begin
        send_clear();
      end else if (pick < 90) begin
        send_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  7'($urandom_range(127)));
      end else begin
        // partial key interrupted by a read or clear, then finished
        for (int i = 0; i < $urandom_range(1, 3); i++)
          send_item(OP_KEY, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)));
        if ($urandom_range(1)) send_read(7'($urandom_range(127)));
        else send_clear();
        send_item(OP_KEY, 8'($urandom_range(255)), 1'b1, 7'($urandom_range(127)));
      end
    end
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] sa;
    logic [31:0] sb;
    logic [7:0]  rl;
    logic        lc;
    for (int p = 0; p < 8; p++) begin
      sa = $urandom;
      sb = $urandom;
      rl = 8'($urandom_range(1, 6));
      lc = 1'($urandom_range(1));
      case (p)
        0: begin
          sa = SEED_A_RST;
          sb = SEED_B_RST;
          rl = REQ_LEN_RST;
          lc = LEN_CHECK_RST;
        end
        1: begin
          sa = '0;
          sb = '0;
          rl = 8'd1;
          lc = 1'b1;
        end
        2: begin
          sa = '1;
          sb = '1;
          rl = 8'd4;
          lc = 1'b1;
        end
        3: begin
          rl = 8'd0;
          lc = 1'b1;
        end
        default: ;
      endcase
      // one phase runs with neither side idling
      quiet_run = (p == 2);
      set_config(sa, sb, rl, lc);
      random_phase(150, rl, lc);
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_basic_ops();
    test_length_rules();
    test_long_keys();
    test_random();
    wait_idle();
    $display("run covered %0d items, %0d results compared", items_sent, results_seen);
    $display("keys inserted %0d, keys rejected %0d", keys_inserted, keys_rejected);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("timeout waiting for the block");
    $display("tb NOT OK");
    $finish;
  end

endmodule
